// ===== design/csd_pkg.sv =====
// ----------------------------------------------------------------------------
// csd_pkg
// Shared widths, register indexes and transaction types of the spectrum divider.
// ----------------------------------------------------------------------------
package csd_pkg;

    localparam int CSD_DATA_WIDTH = 32;
    localparam int CSD_FRAC_BITS  = 16;
    localparam int CSD_EPS_WIDTH  = 16;
    localparam int CSD_ADDR_WIDTH = 2;
    // magnitude of a sum of two full products
    localparam int CSD_MAG_WIDTH  = 2 * CSD_DATA_WIDTH + 1;
    localparam int CSD_MID_DEPTH  = 8;
    localparam int CSD_OUT_DEPTH  = 4;

    // register indexes
    localparam logic [CSD_ADDR_WIDTH-1:0] REG_CONJ_MODE = 2'd0;
    localparam logic [CSD_ADDR_WIDTH-1:0] REG_EPSILON   = 2'd1;

    typedef struct packed {
        logic [CSD_DATA_WIDTH-1:0] a_real;
        logic [CSD_DATA_WIDTH-1:0] a_imag;
        logic [CSD_DATA_WIDTH-1:0] b_real;
        logic [CSD_DATA_WIDTH-1:0] b_imag;
        logic                      real_only;
    } operand_t;

    typedef struct packed {
        logic [CSD_DATA_WIDTH-1:0] q_real;
        logic [CSD_DATA_WIDTH-1:0] q_imag;
        logic                      saturated;
        logic                      zero_divide;
    } result_t;

    typedef struct packed {
        logic                     conj_mode;
        logic [CSD_EPS_WIDTH-1:0] epsilon;
    } cfg_t;

    // classified job handed from the front part to the divider
    typedef struct packed {
        logic [CSD_MAG_WIDTH-1:0] re_mag;
        logic                     re_neg;
        logic [CSD_MAG_WIDTH-1:0] im_mag;
        logic                     im_neg;
        logic [CSD_MAG_WIDTH-1:0] den;
        logic                     zero_divide;
    } div_job_t;

endpackage

// ===== design/csd_fifo.sv =====
// ----------------------------------------------------------------------------
// csd_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
module csd_fifo
    import csd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           din,
    input  logic                       pop,
    output logic [WIDTH-1:0]           dout,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign count = count_reg;

    // checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue read while empty");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count == $past(count) + 1'b1))
        else $error("queue count did not advance on write");

endmodule

// ===== design/csd_front.sv =====
// ----------------------------------------------------------------------------
// csd_front
// Takes operand transactions, forms products, numerators and denominator,
// and classifies real-only and zero-denominator bins into a divider job.
// ----------------------------------------------------------------------------
module csd_front
    import csd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  operand_t operand,
    input  cfg_t     cfg,
    output logic     job_valid,
    output div_job_t job,
    output logic [1:0] inflight
);

    localparam int W  = CSD_DATA_WIDTH;
    localparam int MW = CSD_MAG_WIDTH;
    localparam int EW = CSD_EPS_WIDTH;

    // stage 1: captured operands
    logic     s1_valid_reg;
    operand_t s1_op_reg;
    cfg_t     s1_cfg_reg;

    // stage 2: products
    logic                  s2_valid_reg;
    logic signed [2*W-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg;
    logic signed [2*W-1:0] p_br_reg, p_bi_reg;
    logic signed [2*W-1:0] p_rr_next, p_ii_next, p_ir_next, p_ri_next;
    logic signed [2*W-1:0] p_br_next, p_bi_next;
    logic signed [W:0]     ro_den2_reg, ro_den2_next;
    logic [W-1:0]          ro_num2_reg;
    logic                  ro2_reg, conj2_reg;
    logic [EW-1:0]         eps2_reg;

    // stage 3: sums
    logic              s3_valid_reg;
    logic signed [2*W:0] re_sum_reg, im_sum_reg, re_sum_next, im_sum_next;
    logic [MW-1:0]     den_sum_reg, den_sum_next;
    logic signed [W:0] ro_den3_reg;
    logic [W-1:0]      ro_num3_reg;
    logic              ro3_reg;

    logic signed [W:0] ro_num_ext;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 1 capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg  <= operand;
            s1_cfg_reg <= cfg;
        end
    end

    // products and real-only denominator
    always_comb
    begin
        p_rr_next = $signed(s1_op_reg.a_real) * $signed(s1_op_reg.b_real);
        p_ii_next = $signed(s1_op_reg.a_imag) * $signed(s1_op_reg.b_imag);
        p_ir_next = $signed(s1_op_reg.a_imag) * $signed(s1_op_reg.b_real);
        p_ri_next = $signed(s1_op_reg.a_real) * $signed(s1_op_reg.b_imag);
        p_br_next = $signed(s1_op_reg.b_real) * $signed(s1_op_reg.b_real);
        p_bi_next = $signed(s1_op_reg.b_imag) * $signed(s1_op_reg.b_imag);
        ro_den2_next = $signed({s1_op_reg.b_real[W-1], s1_op_reg.b_real})
                     + $signed({{(W+1-EW){1'b0}}, s1_cfg_reg.epsilon});
    end

    always_ff @(posedge clk)
    begin
        p_rr_reg    <= p_rr_next;
        p_ii_reg    <= p_ii_next;
        p_ir_reg    <= p_ir_next;
        p_ri_reg    <= p_ri_next;
        p_br_reg    <= p_br_next;
        p_bi_reg    <= p_bi_next;
        ro_den2_reg <= ro_den2_next;
        ro_num2_reg <= s1_op_reg.a_real;
        ro2_reg     <= s1_op_reg.real_only;
        conj2_reg   <= s1_cfg_reg.conj_mode;
        eps2_reg    <= s1_cfg_reg.epsilon;
    end

    // numerator sums and |B|^2 plus epsilon
    always_comb
    begin
        if (conj2_reg)
        begin
            re_sum_next = $signed({p_rr_reg[2*W-1], p_rr_reg}) - $signed({p_ii_reg[2*W-1], p_ii_reg});
            im_sum_next = $signed({p_ir_reg[2*W-1], p_ir_reg}) + $signed({p_ri_reg[2*W-1], p_ri_reg});
        end
        else
        begin
            re_sum_next = $signed({p_rr_reg[2*W-1], p_rr_reg}) + $signed({p_ii_reg[2*W-1], p_ii_reg});
            im_sum_next = $signed({p_ir_reg[2*W-1], p_ir_reg}) - $signed({p_ri_reg[2*W-1], p_ri_reg});
        end
        den_sum_next = {1'b0, p_br_reg} + {1'b0, p_bi_reg} + {{(MW-EW){1'b0}}, eps2_reg};
    end

    always_ff @(posedge clk)
    begin
        re_sum_reg  <= re_sum_next;
        im_sum_reg  <= im_sum_next;
        den_sum_reg <= den_sum_next;
        ro_den3_reg <= ro_den2_reg;
        ro_num3_reg <= ro_num2_reg;
        ro3_reg     <= ro2_reg;
    end

    // sign and magnitude split, real-only selection
    always_comb
    begin
        ro_num_ext = $signed({ro_num3_reg[W-1], ro_num3_reg});
        if (ro3_reg)
        begin
            job.re_neg      = ro_num3_reg[W-1] ^ ro_den3_reg[W];
            job.re_mag      = {{(MW-W){1'b0}},
                               ro_num3_reg[W-1] ? W'(-ro_num_ext) : ro_num3_reg};
            job.im_neg      = 1'b0;
            job.im_mag      = '0;
            job.den         = {{(MW-W-1){1'b0}},
                               ro_den3_reg[W] ? (W+1)'(-ro_den3_reg) : ro_den3_reg};
            job.zero_divide = (ro_den3_reg == '0);
        end
        else
        begin
            job.re_neg      = re_sum_reg[2*W];
            job.re_mag      = re_sum_reg[2*W] ? MW'(-re_sum_reg) : re_sum_reg;
            job.im_neg      = im_sum_reg[2*W];
            job.im_mag      = im_sum_reg[2*W] ? MW'(-im_sum_reg) : im_sum_reg;
            job.den         = den_sum_reg;
            job.zero_divide = (den_sum_reg == '0);
        end
    end

    assign job_valid = s3_valid_reg;
    assign inflight  = 2'({1'b0, s1_valid_reg} + {1'b0, s2_valid_reg} + {1'b0, s3_valid_reg});

endmodule

// ===== design/csd_back.sv =====
// ----------------------------------------------------------------------------
// csd_back
// Pipelined restoring divider, one quotient bit per stage for both parts,
// followed by round-to-nearest and saturation.
// ----------------------------------------------------------------------------
module csd_back
    import csd_pkg::*;
#(
    parameter int FRAC_BITS = CSD_FRAC_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  div_job_t job,
    output logic     out_valid,
    output result_t  result
);

    localparam int W    = CSD_DATA_WIDTH;
    localparam int MW   = CSD_MAG_WIDTH;
    localparam int CW   = MW + W + FRAC_BITS + 2;
    localparam int NSTG = W + 1;

    typedef struct packed {
        logic [CW-1:0] rem_re;
        logic [CW-1:0] rem_im;
        logic [W:0]    q_re;
        logic [W:0]    q_im;
        logic [MW-1:0] den;
        logic          re_neg;
        logic          im_neg;
        logic          ovf_re;
        logic          ovf_im;
        logic          zdiv;
    } stage_t;

    stage_t  stage_reg [NSTG+1];
    stage_t  stage_next [NSTG+1];
    logic    valid_reg [NSTG+1];
    result_t out_reg, out_next;
    logic    out_valid_reg;

    logic [CW-1:0] den_top;

    // entry: scale numerators, check for quotients beyond W+1 bits
    always_comb
    begin
        den_top                = {{(CW-MW){1'b0}}, job.den} << (W + 1);
        stage_next[0]          = '0;
        stage_next[0].rem_re   = {{(CW-MW){1'b0}}, job.re_mag} << (FRAC_BITS + 1);
        stage_next[0].rem_im   = {{(CW-MW){1'b0}}, job.im_mag} << (FRAC_BITS + 1);
        stage_next[0].den      = job.den;
        stage_next[0].re_neg   = job.re_neg;
        stage_next[0].im_neg   = job.im_neg;
        stage_next[0].ovf_re   = (stage_next[0].rem_re >= den_top);
        stage_next[0].ovf_im   = (stage_next[0].rem_im >= den_top);
        stage_next[0].zdiv     = job.zero_divide;
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < NSTG; j++)
    begin : g_stage
        logic [CW-1:0] den_sh;
        always_comb
        begin
            den_sh        = {{(CW-MW){1'b0}}, stage_reg[j].den} << (W - j);
            stage_next[j+1] = stage_reg[j];
            if (stage_reg[j].rem_re >= den_sh)
            begin
                stage_next[j+1].rem_re      = stage_reg[j].rem_re - den_sh;
                stage_next[j+1].q_re[W - j] = 1'b1;
            end
            if (stage_reg[j].rem_im >= den_sh)
            begin
                stage_next[j+1].rem_im      = stage_reg[j].rem_im - den_sh;
                stage_next[j+1].q_im[W - j] = 1'b1;
            end
        end
    end

    // stage registers move together
    for (genvar j = 0; j <= NSTG; j++)
    begin : g_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= (j == 0) ? in_valid : valid_reg[(j == 0) ? 0 : j - 1];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[j] <= stage_next[j];
            end
        end
    end

    // rounding and saturation of one quotient part
    function automatic logic [W:0] round_mag(input logic [W:0] q, input logic neg,
                                             input logic ovf, output logic clip);
        logic [W+1:0] qp;
        logic [W:0]   r;
        logic [W:0]   lim;
        begin
            qp   = {1'b0, q} + 1'b1;
            r    = qp[W+1:1];
            lim  = neg ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
            clip = ovf || (r > lim);
            round_mag = clip ? lim : r;
        end
    endfunction

    always_comb
    begin
        logic [W:0] m_re, m_im;
        logic       c_re, c_im;
        m_re = round_mag(stage_reg[NSTG].q_re, stage_reg[NSTG].re_neg,
                         stage_reg[NSTG].ovf_re, c_re);
        m_im = round_mag(stage_reg[NSTG].q_im, stage_reg[NSTG].im_neg,
                         stage_reg[NSTG].ovf_im, c_im);
        if (stage_reg[NSTG].zdiv)
        begin
            out_next = '0;
            out_next.zero_divide = 1'b1;
        end
        else
        begin
            out_next.q_real      = stage_reg[NSTG].re_neg ? W'(-m_re) : m_re[W-1:0];
            out_next.q_imag      = stage_reg[NSTG].im_neg ? W'(-m_im) : m_im[W-1:0];
            out_next.saturated   = c_re || c_im;
            out_next.zero_divide = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

// ===== design/complex_spectrum_divider.sv =====
// ----------------------------------------------------------------------------
// complex_spectrum_divider
// Fixed-point complex bin division A/B or A/conj(B) with epsilon, rounding
// and saturation.
// ----------------------------------------------------------------------------
// One operand transaction is taken per clock while full is low, and one
// result transaction is given per operand, in order. Its path to the
// result ports: the accept edge captures the operands, then the product
// and sum stages, the job queue write, the entry stage, 33 divider
// stages (one quotient bit each), the rounding register and the output
// queue write. The divider pipeline halts as a whole while the 4-entry
// output queue is full; the 8-entry job queue keeps the front accepting
// meanwhile, and full rises once the job queue plus the three front
// stages hold 8 transactions. There is no clearing pass after reset.
module complex_spectrum_divider
    import csd_pkg::*;
#(
    parameter int FRAC_BITS = CSD_FRAC_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  operand_t                  operand,
    output logic                      empty,
    input  logic                      pop,
    output result_t                   result,
    input  logic                      wr_en,
    input  logic [CSD_ADDR_WIDTH-1:0] wr_addr,
    input  logic [CSD_EPS_WIDTH-1:0]  wr_data
);

    localparam int MCW = $clog2(CSD_MID_DEPTH + 1);
    localparam int OCW = $clog2(CSD_OUT_DEPTH + 1);

    cfg_t     cfg_reg, cfg_next;
    logic     accept;
    logic     job_valid;
    div_job_t front_job, mid_job;
    logic [1:0] inflight;
    logic     mid_full, mid_empty, mid_pop;
    logic [MCW-1:0] mid_count;
    logic     back_en, back_valid, out_push, out_full;
    result_t  back_result;
    logic [OCW-1:0] out_count;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_addr)
                REG_CONJ_MODE: cfg_next.conj_mode = wr_data[0];
                REG_EPSILON:   cfg_next.epsilon   = wr_data;
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conj_mode <= 1'b0;
            cfg_reg.epsilon   <= CSD_EPS_WIDTH'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // credit check against the job queue
    assign full   = (({1'b0, mid_count} + (MCW+1)'(inflight)) >= (MCW+1)'(CSD_MID_DEPTH));
    assign accept = push && !full;

    csd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operand   (operand),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (front_job),
        .inflight  (inflight)
    );

    csd_fifo #(
        .WIDTH ($bits(div_job_t)),
        .DEPTH (CSD_MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_valid),
        .din   (front_job),
        .pop   (mid_pop),
        .dout  (mid_job),
        .full  (mid_full),
        .empty (mid_empty),
        .count (mid_count)
    );

    // divider advances while the output queue has room
    assign back_en  = !out_full;
    assign mid_pop  = back_en && !mid_empty;
    assign out_push = back_en && back_valid;

    csd_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (!mid_empty),
        .job       (mid_job),
        .out_valid (back_valid),
        .result    (back_result)
    );

    csd_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (CSD_OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (back_result),
        .pop   (pop && !empty),
        .dout  (result),
        .full  (out_full),
        .empty (empty),
        .count (out_count)
    );

    // checks
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (({1'b0, mid_count} + (MCW+1)'(inflight)) <= (MCW+1)'(CSD_MID_DEPTH)))
        else $error("job queue credit exceeded");
    a_mid_room: assert property (@(posedge clk) disable iff (!rst_n)
        !(job_valid && mid_full && !mid_pop))
        else $error("front delivered a job with no queue room");
    a_zdiv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.zero_divide) |->
        (result.q_real == '0 && result.q_imag == '0 && !result.saturated))
        else $error("zero-divide transaction carries a nonzero quotient");
    a_out_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_count <= OCW'(CSD_OUT_DEPTH))
        else $error("output queue level out of range");

endmodule
